>>> rtl/top_level_assignment_finder_defines.svh
// Assertion macros used by the assignment finder scanner.
`ifndef TOP_LEVEL_ASSIGNMENT_FINDER_DEFINES_SVH
`define TOP_LEVEL_ASSIGNMENT_FINDER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define TAF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define TAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/taf_pkg.sv
// Types and constants shared by the assignment finder modules.
`timescale 1ns / 1ps
`default_nettype none

package taf_pkg;

  localparam int MAX_TEXT_LEN = 65536;
  localparam int DEPTH_MAX    = 255;

  localparam int IDX_W   = 16;
  localparam int DEPTH_W = $clog2(DEPTH_MAX + 1);

  localparam int LAST_INDEX_INT = (MAX_TEXT_LEN - 1 > 65535) ? 65535 : MAX_TEXT_LEN - 1;
  localparam logic [IDX_W-1:0]   LAST_INDEX = IDX_W'(LAST_INDEX_INT);
  localparam logic [DEPTH_W-1:0] DEPTH_TOP  = DEPTH_W'(DEPTH_MAX);

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LCURL  = 8'h7B;
  localparam logic [7:0] CH_RCURL  = 8'h7D;

  typedef struct packed {
    logic       end_of_text;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic             depth_overflow;
    logic [IDX_W-1:0] position;
    logic             found;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/taf_scan.sv
// Scanner state and the per-character update of depths, strings and candidates.
`timescale 1ns / 1ps
`default_nettype none
`include "top_level_assignment_finder_defines.svh"

module taf_scan (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire taf_pkg::item_t    item,
  output taf_pkg::result_t       result
);

  logic [taf_pkg::DEPTH_W-1:0] paren_depth, paren_depth_next;
  logic [taf_pkg::DEPTH_W-1:0] square_depth, square_depth_next;
  logic [taf_pkg::DEPTH_W-1:0] curly_depth, curly_depth_next;
  logic inside_quotes, inside_quotes_next;
  logic escape_pending, escape_pending_next;
  logic [7:0] previous_char, previous_char_next;
  logic candidate_pending, candidate_pending_next;
  logic [taf_pkg::IDX_W-1:0] candidate_index, candidate_index_next;
  logic match_done, match_done_next;
  logic [taf_pkg::IDX_W-1:0] match_index, match_index_next;
  logic [taf_pkg::IDX_W-1:0] char_counter, char_counter_next;
  logic overflow_seen, overflow_seen_next;
  logic past_limit, past_limit_next;

  logic [7:0] c;
  logic       top_level;
  logic       prev_blocks;
  logic       depth_in_range;
  logic       state_cleared;

  assign c           = item.char_code;
  assign top_level   = (paren_depth == '0) && (square_depth == '0) && (curly_depth == '0);
  assign prev_blocks = (previous_char == taf_pkg::CH_EQ) || (previous_char == taf_pkg::CH_BANG) ||
                       (previous_char == taf_pkg::CH_LT) || (previous_char == taf_pkg::CH_GT);

  assign depth_in_range = (paren_depth <= taf_pkg::DEPTH_TOP) &&
                          (square_depth <= taf_pkg::DEPTH_TOP) &&
                          (curly_depth <= taf_pkg::DEPTH_TOP);
  assign state_cleared  = (char_counter == '0) && !match_done && !overflow_seen;

  always_comb begin
    paren_depth_next       = paren_depth;
    square_depth_next      = square_depth;
    curly_depth_next       = curly_depth;
    inside_quotes_next     = inside_quotes;
    escape_pending_next    = escape_pending;
    candidate_pending_next = candidate_pending;
    candidate_index_next   = candidate_index;
    match_done_next        = match_done;
    match_index_next       = match_index;
    char_counter_next      = char_counter;
    overflow_seen_next     = overflow_seen;
    past_limit_next        = past_limit;
    previous_char_next     = c;
    result                 = '0;

    // A pending '=' is confirmed unless this character is another '='.
    if (candidate_pending) begin
      if (c != taf_pkg::CH_EQ && !match_done) begin
        match_done_next  = 1'b1;
        match_index_next = candidate_index;
      end
      candidate_pending_next = 1'b0;
    end

    if (inside_quotes) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
      end else if (c == taf_pkg::CH_BSLASH) begin
        escape_pending_next = 1'b1;
      end else if (c == taf_pkg::CH_QUOTE) begin
        inside_quotes_next = 1'b0;
      end
    end else begin
      case (c)
        taf_pkg::CH_QUOTE: inside_quotes_next = 1'b1;
        taf_pkg::CH_LPAR: begin
          if (paren_depth >= taf_pkg::DEPTH_TOP) overflow_seen_next = 1'b1;
          else paren_depth_next = paren_depth + 1'b1;
        end
        taf_pkg::CH_RPAR: begin
          if (paren_depth != '0) paren_depth_next = paren_depth - 1'b1;
        end
        taf_pkg::CH_LSQ: begin
          if (square_depth >= taf_pkg::DEPTH_TOP) overflow_seen_next = 1'b1;
          else square_depth_next = square_depth + 1'b1;
        end
        taf_pkg::CH_RSQ: begin
          if (square_depth != '0) square_depth_next = square_depth - 1'b1;
        end
        taf_pkg::CH_LCURL: begin
          if (curly_depth >= taf_pkg::DEPTH_TOP) overflow_seen_next = 1'b1;
          else curly_depth_next = curly_depth + 1'b1;
        end
        taf_pkg::CH_RCURL: begin
          if (curly_depth != '0) curly_depth_next = curly_depth - 1'b1;
        end
        taf_pkg::CH_EQ: begin
          if (top_level && !past_limit && !match_done_next && !prev_blocks) begin
            candidate_pending_next = 1'b1;
            candidate_index_next   = char_counter;
          end
        end
        default: ;
      endcase
    end

    if (!past_limit) begin
      if (char_counter == taf_pkg::LAST_INDEX) past_limit_next = 1'b1;
      else char_counter_next = char_counter + 1'b1;
    end

    // On the final character a candidate counts as confirmed; then all state clears.
    if (item.end_of_text) begin
      result.found          = match_done_next || candidate_pending_next;
      result.position       = match_done_next ? match_index_next :
                              (candidate_pending_next ? candidate_index_next : '0);
      result.depth_overflow = overflow_seen_next;
      paren_depth_next       = '0;
      square_depth_next      = '0;
      curly_depth_next       = '0;
      inside_quotes_next     = 1'b0;
      escape_pending_next    = 1'b0;
      previous_char_next     = '0;
      candidate_pending_next = 1'b0;
      candidate_index_next   = '0;
      match_done_next        = 1'b0;
      match_index_next       = '0;
      char_counter_next      = '0;
      overflow_seen_next     = 1'b0;
      past_limit_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      paren_depth       <= '0;
      square_depth      <= '0;
      curly_depth       <= '0;
      inside_quotes     <= 1'b0;
      escape_pending    <= 1'b0;
      previous_char     <= '0;
      candidate_pending <= 1'b0;
      candidate_index   <= '0;
      match_done        <= 1'b0;
      match_index       <= '0;
      char_counter      <= '0;
      overflow_seen     <= 1'b0;
      past_limit        <= 1'b0;
    end else if (adv) begin
      paren_depth       <= paren_depth_next;
      square_depth      <= square_depth_next;
      curly_depth       <= curly_depth_next;
      inside_quotes     <= inside_quotes_next;
      escape_pending    <= escape_pending_next;
      previous_char     <= previous_char_next;
      candidate_pending <= candidate_pending_next;
      candidate_index   <= candidate_index_next;
      match_done        <= match_done_next;
      match_index       <= match_index_next;
      char_counter      <= char_counter_next;
      overflow_seen     <= overflow_seen_next;
      past_limit        <= past_limit_next;
    end
  end

  `TAF_ASSERT_NOW(a_depth_bound, 1'b1, depth_in_range, "nesting depth above its bound")
  `TAF_ASSERT_NOW(a_escape_in_string, escape_pending, inside_quotes, "escape outside a string")
  `TAF_ASSERT_NOW(a_single_match, candidate_pending, !match_done, "candidate after a match")
  `TAF_ASSERT_NEXT(a_clear_after_last, adv && item.end_of_text, state_cleared, "state not cleared")

endmodule

`default_nettype wire

>>> rtl/taf_out_reg.sv
// Output register that holds one result word until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module taf_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire taf_pkg::result_t  result,
  input  wire logic              m_tready,
  output logic                   m_tvalid,
  output logic [23:0]            m_tdata
);

  taf_pkg::result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_tdata = {6'b0, held};

endmodule

`default_nettype wire

>>> rtl/top_level_assignment_finder.sv
// Top level of the assignment finder: input register, scanner and output register.
`timescale 1ns / 1ps
`default_nettype none

// The block scans a text one character per word and reports, on the word
// marked with tlast, whether an '=' stood outside all parentheses, brackets,
// braces and double-quoted strings and was not part of '==', '!=', '<=' or
// '>='. The result word carries the zero-based position of the first such
// sign and a flag that tells whether an opener met a nesting depth already
// at its bound during the text. Each character word is captured in an input
// register; the scanner state is updated from it as it leaves that register,
// and at that edge a final word's result loads the output register and
// m_tvalid rises. So one word is taken every clock cycle unless a final word
// is stalled. The only stall comes from the output register: a final
// character waits in the input register while an earlier result has not
// yet been taken.
// Characters beyond index 65535 still steer depths and strings but cannot
// be reported as a position.

module top_level_assignment_finder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tlast,   // end_of_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // [0] found, [16:1] position, [17] depth_overflow
);

  logic             in_valid;
  taf_pkg::item_t   in_item;
  logic             adv;
  taf_pkg::result_t result;

  // A word with no result always moves on; a final word needs the output slot.
  assign adv      = in_valid && (!in_item.end_of_text || !m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.char_code   <= s_tdata;
      in_item.end_of_text <= s_tlast;
    end
  end

  taf_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .item   (in_item),
    .result (result)
  );

  taf_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (adv && in_item.end_of_text),
    .result   (result),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

>>> tb/sv/top_level_assignment_finder_tb.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the top-level assignment finder.
module top_level_assignment_finder_tb;
  import taf_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_WORDS = 400;
  localparam int REPORT_MAX  = 10;
  localparam int HOLD_CYCLES = 400;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TOP     = 8'hFF;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  always #5 clk = ~clk;

  top_level_assignment_finder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Results still owed by the block, oldest first.
  result_t     pending_results[$];
  logic [7:0]  text_buf[$];
  int          words_sent = 0;
  int          bad_words  = 0;
  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          cycle_count = 0;
  logic        hold_req   = 1'b0;
  int          hold_left  = 0;

  // Scanner state as the block should hold it.
  logic [DEPTH_W-1:0] paren_lvl, square_lvl, curly_lvl;
  logic               quote_open, escape_next;
  logic [7:0]         prior_char;
  logic               eq_waiting, hit_done, depth_hit, index_frozen;
  logic [IDX_W-1:0]   eq_at, hit_at, char_at;

  // Short texts with known outcomes. Only final words carry a result.
  typedef struct {
    logic [7:0] ch;
    bit         last;
    bit         typed;
    bit         found;
    int         pos;
    bit         ovf;
  } dir_row_t;

  dir_row_t directed_text [24] = '{
    // A lone sign: the byte before is NUL and the byte after is taken as NUL.
    '{CH_EQ,     1, 1, 1, 0, 0},
    // A doubled sign is a comparison.
    '{CH_EQ,     0, 0, 0, 0, 0}, '{CH_EQ,     1, 1, 0, 0, 0},
    // Each of the other comparison operators.
    '{CH_BANG,   0, 0, 0, 0, 0}, '{CH_EQ,     0, 0, 0, 0, 0},
    '{CH_LT,     0, 0, 0, 0, 0}, '{CH_EQ,     0, 0, 0, 0, 0},
    '{CH_GT,     0, 0, 0, 0, 0}, '{CH_EQ,     1, 1, 0, 0, 0},
    // A sign inside parentheses does not count.
    '{CH_LPAR,   0, 0, 0, 0, 0}, '{CH_EQ,     0, 0, 0, 0, 0},
    '{CH_RPAR,   1, 1, 0, 0, 0},
    // An escaped quote keeps the string open across the inner sign.
    '{CH_QUOTE,  0, 0, 0, 0, 0}, '{CH_BSLASH, 0, 0, 0, 0, 0},
    '{CH_QUOTE,  0, 0, 0, 0, 0}, '{CH_EQ,     0, 0, 0, 0, 0},
    '{CH_QUOTE,  0, 0, 0, 0, 0}, '{CH_EQ,     1, 0, 0, 0, 0},
    // Closers at depth zero stay at zero; extreme byte values around the sign.
    '{CH_RPAR,   0, 0, 0, 0, 0}, '{CH_RSQ,    0, 0, 0, 0, 0},
    '{CH_RCURL,  0, 0, 0, 0, 0}, '{CH_NUL,    0, 0, 0, 0, 0},
    '{CH_EQ,     0, 0, 0, 0, 0}, '{CH_TOP,    1, 1, 1, 4, 0}
  };

  function automatic void clear_scan();
    paren_lvl    = '0;
    square_lvl   = '0;
    curly_lvl    = '0;
    quote_open   = 1'b0;
    escape_next  = 1'b0;
    prior_char   = CH_NUL;
    eq_waiting   = 1'b0;
    eq_at        = '0;
    hit_done     = 1'b0;
    hit_at       = '0;
    char_at      = '0;
    depth_hit    = 1'b0;
    index_frozen = 1'b0;
  endfunction

  function automatic logic [DEPTH_W-1:0] deepen(input logic [DEPTH_W-1:0] lvl);
    if (lvl >= DEPTH_TOP) begin
      depth_hit = 1'b1;
      return DEPTH_TOP;
    end
    return lvl + 1'b1;
  endfunction

  function automatic logic [DEPTH_W-1:0] shallower(input logic [DEPTH_W-1:0] lvl);
    return (lvl == '0) ? lvl : lvl - 1'b1;
  endfunction

  function automatic void take_candidate();
    if (eq_waiting && !hit_done) begin
      hit_done = 1'b1;
      hit_at   = eq_at;
    end
    eq_waiting = 1'b0;
  endfunction

  // Advances the scan by one character; returns 1 with the result on a final one.
  function automatic bit scan_char(input logic [7:0] c, input bit last, output result_t res);
    int next_at;
    res = '0;
    // A waiting sign is settled by the byte that follows it.
    if (eq_waiting) begin
      if (c != CH_EQ) take_candidate();
      else eq_waiting = 1'b0;
    end
    if (quote_open) begin
      if (escape_next) escape_next = 1'b0;
      else if (c == CH_BSLASH) escape_next = 1'b1;
      else if (c == CH_QUOTE) quote_open = 1'b0;
    end else begin
      case (c)
        CH_QUOTE: quote_open = 1'b1;
        CH_LPAR:  paren_lvl  = deepen(paren_lvl);
        CH_RPAR:  paren_lvl  = shallower(paren_lvl);
        CH_LSQ:   square_lvl = deepen(square_lvl);
        CH_RSQ:   square_lvl = shallower(square_lvl);
        CH_LCURL: curly_lvl  = deepen(curly_lvl);
        CH_RCURL: curly_lvl  = shallower(curly_lvl);
        CH_EQ: begin
          if (paren_lvl == '0 && square_lvl == '0 && curly_lvl == '0 && !index_frozen &&
              !hit_done && prior_char != CH_EQ && prior_char != CH_BANG &&
              prior_char != CH_LT && prior_char != CH_GT) begin
            eq_waiting = 1'b1;
            eq_at      = char_at;
          end
        end
        default: ;
      endcase
    end
    prior_char = c;
    // The index stops at the last position that a result can report.
    if (!index_frozen) begin
      next_at = int'(char_at) + 1;
      if (next_at > 65535 || next_at >= MAX_TEXT_LEN) index_frozen = 1'b1;
      else char_at = IDX_W'(next_at);
    end
    if (!last) return 1'b0;
    take_candidate();
    res.found          = hit_done;
    res.position       = hit_done ? hit_at : '0;
    res.depth_overflow = depth_hit;
    clear_scan();
    return 1'b1;
  endfunction

  // Offers one word, waits for the handshake and records what it should cause.
  task automatic send_word(input logic [7:0] c, input bit last, input bit typed,
                           input result_t typed_res);
    result_t predicted;
    bit      has_res;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    has_res = scan_char(c, last, predicted);
    if (has_res) pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic send_text();
    result_t no_typed;
    no_typed = '0;
    foreach (text_buf[i]) send_word(text_buf[i], i == text_buf.size() - 1, 1'b0, no_typed);
  endtask

  task automatic await_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(15))
      0, 1:    return CH_EQ;
      2:       return CH_BANG;
      3:       return CH_LT;
      4:       return CH_GT;
      5:       return CH_QUOTE;
      6:       return CH_BSLASH;
      7:       return CH_LPAR;
      8:       return CH_RPAR;
      9:       return CH_LSQ;
      10:      return CH_RSQ;
      11:      return CH_LCURL;
      12:      return CH_RCURL;
      13:      return CH_LOWER_A + 8'($urandom_range(25));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_ident();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) text_buf.push_back(CH_LOWER_A + 8'($urandom_range(25)));
  endtask

  // A quoted string whose body holds signs and escapes.
  task automatic add_quoted();
    int n;
    text_buf.push_back(CH_QUOTE);
    n = $urandom_range(0, 5);
    repeat (n) begin
      case ($urandom_range(3))
        0: begin
          text_buf.push_back(CH_BSLASH);
          text_buf.push_back(pick_noise());
        end
        1:       text_buf.push_back(CH_EQ);
        default: text_buf.push_back(CH_LOWER_A + 8'($urandom_range(25)));
      endcase
    end
    text_buf.push_back(CH_QUOTE);
  endtask

  // Builds one text. Low kinds give statement-shaped text, then loose noise,
  // then raw bytes; the top kinds nest one bracket type to around or past its bound.
  task automatic compose_text(input int kind);
    int         n;
    int         depth;
    logic [7:0] opener;
    logic [7:0] closer;
    text_buf.delete();
    if (kind < 60) begin
      if ($urandom_range(4) == 0) add_quoted();
      add_ident();
      if ($urandom_range(2) == 0) begin
        text_buf.push_back(CH_LSQ);
        add_ident();
        if ($urandom_range(1) == 1) begin
          text_buf.push_back(CH_EQ);
          add_ident();
        end
        text_buf.push_back(CH_RSQ);
      end
      case ($urandom_range(6))
        0:       text_buf.push_back(CH_BANG);
        1:       text_buf.push_back(CH_LT);
        2:       text_buf.push_back(CH_GT);
        3:       text_buf.push_back(CH_EQ);
        4:       text_buf.push_back(CH_PLUS);
        default: ;
      endcase
      text_buf.push_back(CH_EQ);
      if ($urandom_range(5) == 0) text_buf.push_back(CH_EQ);
      n = $urandom_range(1, 4);
      repeat (n) begin
        case ($urandom_range(5))
          0: add_ident();
          1: begin
            text_buf.push_back(CH_LPAR);
            add_ident();
            text_buf.push_back(CH_EQ);
            add_ident();
            text_buf.push_back(CH_RPAR);
          end
          2: add_quoted();
          3: begin
            text_buf.push_back(CH_LCURL);
            add_ident();
            text_buf.push_back(CH_EQ);
            text_buf.push_back(CH_RCURL);
          end
          4: text_buf.push_back(CH_EQ);
          default: text_buf.push_back(pick_noise());
        endcase
      end
    end else if (kind < 85) begin
      n = $urandom_range(1, 30);
      repeat (n) text_buf.push_back(pick_noise());
    end else if (kind < 97) begin
      n = $urandom_range(1, 20);
      repeat (n) text_buf.push_back(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(2))
        0: begin opener = CH_LPAR;  closer = CH_RPAR;  end
        1: begin opener = CH_LSQ;   closer = CH_RSQ;   end
        default: begin opener = CH_LCURL; closer = CH_RCURL; end
      endcase
      // Forced deep texts always pass the bound; random ones land around it.
      depth = (kind >= 100) ? DEPTH_MAX + 1 : DEPTH_MAX - 2 + $urandom_range(0, 6);
      repeat (depth) text_buf.push_back(opener);
      text_buf.push_back(CH_EQ);
      n = $urandom_range(depth - 3, depth + 2);
      repeat (n) text_buf.push_back(closer);
      add_ident();
      text_buf.push_back(CH_EQ);
      add_ident();
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    if (hold_req || hold_left != 0) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    result_t want;
    result_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen = result_t'(m_tdata[17:0]);
      if (pending_results.size() == 0) begin
        bad_words++;
        if (bad_words <= REPORT_MAX)
          $display("unexpected result word %h at cycle %0d", m_tdata, cycle_count);
      end else begin
        want = pending_results.pop_front();
        if (seen.found !== want.found || seen.position !== want.position ||
            seen.depth_overflow !== want.depth_overflow || m_tdata[23:18] !== '0) begin
          bad_words++;
          if (bad_words <= REPORT_MAX)
            $display("result mismatch at cycle %0d: expected found=%0d position=%0d ovf=%0d,%s",
                     cycle_count, want.found, want.position, want.depth_overflow,
                     $sformatf(" got found=%0d position=%0d ovf=%0d (word %h)",
                               seen.found, seen.position, seen.depth_overflow, m_tdata));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    result_t want;
    int      phase;
    int      phase_start;
    clear_scan();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_text[i]) begin
      want.found          = directed_text[i].found;
      want.position       = IDX_W'(directed_text[i].pos);
      want.depth_overflow = directed_text[i].ovf;
      send_word(directed_text[i].ch, directed_text[i].last, directed_text[i].typed, want);
    end
    await_drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 57; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      phase_start = words_sent;
      if (phase == 0) begin
        compose_text(100);
        send_text();
        await_drain();
        phase_start = words_sent;
        // Hold the receiver off while short texts pile up behind the output.
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (40) begin
          text_buf.delete();
          add_ident();
          if ($urandom_range(1) == 1) text_buf.push_back(CH_EQ);
          send_text();
        end
        await_drain();
      end
      while (words_sent - phase_start < PHASE_WORDS) begin
        compose_text($urandom_range(99));
        send_text();
      end
      await_drain();
    end

    repeat (10) @(posedge clk);
    if (bad_words == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/taf_pkg.sv
rtl/taf_scan.sv
rtl/taf_out_reg.sv
rtl/top_level_assignment_finder.sv
tb/sv/top_level_assignment_finder_tb.sv
